// ===== hdl/chained_hash_set_assert.svh =====
// Assertion macros for the chained hash set.
// Used by the top level only; no other dependencies.
`ifndef CHAINED_HASH_SET_ASSERT_SVH
`define CHAINED_HASH_SET_ASSERT_SVH
// Implication checked every edge outside reset.
`define CHS_ASSERT_IMP(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
// Next-cycle implication.
`define CHS_ASSERT_NXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ===== hdl/chs_pkg.sv =====
// Package for the chained hash set: constants and beat types.
// No dependencies.
`default_nettype none
package chs_pkg;
  localparam int MaxBuckets = 1024;
  localparam int NodePool   = 1024;
  localparam int KeyBits    = 31;
  localparam int CfgBits    = 11;
  localparam logic [CfgBits-1:0] BucketReset = 11'd11;

  typedef enum logic {
    OP_FIND   = 1'b0,
    OP_INSERT = 1'b1
  } op_t;

  typedef struct packed {
    logic                operation;
    logic [KeyBits-1:0]  key;
  } in_beat_t;

  typedef struct packed {
    logic found;
    logic inserted;
    logic pool_full;
  } out_beat_t;
endpackage
`default_nettype wire

// ===== hdl/chained_hash_set.sv =====
// Flow: a bit-serial modulo over the KEY_BITS key bits picks the bucket, one head read follows,
// then each chain node is read and compared until a match or the chain end; an insert that misses
// while the pool has room links a new node at the head of the chain before out_valid rises.
// The block takes one item at a time; in_stall stays high until out_valid is taken with out_stall low.
// After reset a clearing pass zeroes the MAX_BUCKETS head entries, one per cycle,
// with in_stall high; nodes_used resets to zero and bucket_count to 11.
`default_nettype none
`include "chained_hash_set_assert.svh"
module chained_hash_set #(
  parameter int MAX_BUCKETS = chs_pkg::MaxBuckets,
  parameter int NODE_POOL   = chs_pkg::NodePool
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          cfg_we,
  input  wire  [chs_pkg::CfgBits-1:0]  cfg_data,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire  chs_pkg::in_beat_t      in_data,
  output logic                         out_valid,
  input  wire                          out_stall,
  output chs_pkg::out_beat_t           out_data
);
  localparam int KEY_BITS = chs_pkg::KeyBits;
  localparam int BB = $clog2(MAX_BUCKETS);
  localparam int NB = $clog2(NODE_POOL);
  localparam int LB = NB + 1;
  localparam int CB = chs_pkg::CfgBits;
  localparam int DB = (BB + 1 > CB) ? BB + 1 : CB;

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_MOD   = 8'b0000_0100,
    S_HEAD  = 8'b0000_1000,
    S_LINK  = 8'b0001_0000,
    S_NODE  = 8'b0010_0000,
    S_WRITE = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t state;
  logic [CB-1:0]        bucket_count;
  logic [BB-1:0]        clr_addr;
  logic [LB-1:0]        nodes_used;
  logic [KEY_BITS-1:0]  key;
  logic                 op;
  logic [BB-1:0]        bucket;
  logic [LB-1:0]        link;
  logic [LB-1:0]        head;
  logic [LB-1:0]        steps;

  logic [LB-1:0]        heads [MAX_BUCKETS];
  logic [KEY_BITS-1:0]  nkeys [NODE_POOL];
  logic [LB-1:0]        nlinks[NODE_POOL];
  logic [LB-1:0]        head_rd;
  logic [KEY_BITS-1:0]  nkey_rd;
  logic [LB-1:0]        nlink_rd;

  logic [DB-1:0]        div_w;
  logic [DB-1:0]        eff;
  logic                 mod_start, mod_done;
  logic [DB-1:0]        mod_rem;

  always_comb begin
    div_w = DB'(bucket_count);
    if (div_w == '0) eff = DB'(1);
    else if (div_w > DB'(MAX_BUCKETS)) eff = DB'(MAX_BUCKETS);
    else eff = div_w;
  end

  assign mod_start = (state == S_IDLE) && in_valid;

  chs_mod #(.KEY_BITS(KEY_BITS), .DIV_BITS(DB)) u_mod (
    .clk(clk), .rst(rst), .start(mod_start), .dividend(in_data.key),
    .divisor(eff), .done(mod_done), .remainder(mod_rem)
  );

  logic head_we, node_we;
  logic [BB-1:0] head_waddr;
  logic [LB-1:0] head_wdata;
  logic [LB-1:0] cur_link;
  logic [NB-1:0] node_addr;

  // first step of a walk takes the link straight from the head read
  assign cur_link   = (steps == '0) ? head_rd : link;
  assign head_we    = (state == S_CLEAR) || (state == S_WRITE);
  assign head_waddr = (state == S_CLEAR) ? clr_addr : bucket;
  assign head_wdata = (state == S_CLEAR) ? '0 : nodes_used + 1'b1;
  assign node_we    = (state == S_WRITE);
  assign node_addr  = node_we ? nodes_used[NB-1:0] : NB'(cur_link - 1'b1);

  always_ff @(posedge clk) begin
    if (head_we) heads[head_waddr] <= head_wdata;
    head_rd <= heads[bucket];
  end

  always_ff @(posedge clk) begin
    if (node_we) begin
      nkeys[node_addr]  <= key;
      nlinks[node_addr] <= head;
    end
    nkey_rd  <= nkeys[node_addr];
    nlink_rd <= nlinks[node_addr];
  end

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      nodes_used   <= '0;
      bucket_count <= chs_pkg::BucketReset;
    end else begin
      if (cfg_we) bucket_count <= cfg_data;
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == BB'(MAX_BUCKETS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            key   <= in_data.key;
            op    <= in_data.operation;
            state <= S_MOD;
          end
        end
        S_MOD: begin
          if (mod_done) begin
            bucket <= mod_rem[BB-1:0];
            state  <= S_HEAD;
          end
        end
        S_HEAD: begin
          // head_rd is registered from heads[bucket], so it is valid in S_LINK
          state <= S_LINK;
          steps <= '0;
        end
        S_LINK: begin
          if (steps == '0) begin
            head <= head_rd;
            link <= head_rd;
          end
          if (cur_link == '0 || steps == LB'(NODE_POOL)) begin
            if (op == chs_pkg::OP_INSERT && nodes_used < LB'(NODE_POOL)) state <= S_WRITE;
            else state <= S_OUT;
            out_data.found     <= 1'b0;
            out_data.inserted  <= 1'b0;
            out_data.pool_full <= (op == chs_pkg::OP_INSERT);
          end else begin
            state <= S_NODE;
          end
        end
        S_NODE: begin
          steps <= steps + 1'b1;
          if (nkey_rd == key) begin
            out_data.found     <= 1'b1;
            out_data.inserted  <= 1'b0;
            out_data.pool_full <= 1'b0;
            state <= S_OUT;
          end else begin
            link  <= nlink_rd;
            state <= S_LINK;
          end
        end
        S_WRITE: begin
          nodes_used         <= nodes_used + 1'b1;
          out_data.inserted  <= 1'b1;
          out_data.pool_full <= 1'b0;
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) state <= S_IDLE;
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  // node allocation must never run past the pool
  `CHS_ASSERT_IMP(a_used_max, 1'b1, nodes_used <= LB'(NODE_POOL))
  `CHS_ASSERT_IMP(a_one_flag, out_valid,
    !(out_data.found && out_data.inserted) && !(out_data.inserted && out_data.pool_full))
  `CHS_ASSERT_NXT(a_alloc, state == S_WRITE, nodes_used == $past(nodes_used) + 1'b1)
  `CHS_ASSERT_IMP(a_link_ok, state == S_NODE, link <= nodes_used && link != '0)
endmodule
`default_nettype wire

// ===== hdl/chs_mod.sv =====
// Sequential remainder unit: key modulo divisor, one quotient bit per cycle.
// Depends on chs_pkg.
`default_nettype none
module chs_mod #(
  parameter int KEY_BITS = chs_pkg::KeyBits,
  parameter int DIV_BITS = 11
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 start,
  input  wire  [KEY_BITS-1:0] dividend,
  input  wire  [DIV_BITS-1:0] divisor,
  output logic                done,
  output logic [DIV_BITS-1:0] remainder
);
  localparam int CntBits = $clog2(KEY_BITS + 1);

  logic [KEY_BITS-1:0] shreg;
  logic [DIV_BITS:0]   rem;
  logic [DIV_BITS-1:0] dv;
  logic [CntBits-1:0]  cnt;
  logic                busy;
  logic [DIV_BITS:0]   trial;
  logic [DIV_BITS:0]   diff;

  always_comb begin
    trial = {rem[DIV_BITS-1:0], shreg[KEY_BITS-1]};
    diff  = trial - {1'b0, dv};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        shreg <= dividend;
        dv    <= divisor;
        rem   <= '0;
        cnt   <= CntBits'(KEY_BITS);
      end else if (busy) begin
        shreg <= shreg << 1;
        rem   <= diff[DIV_BITS] ? trial : diff;
        cnt   <= cnt - 1'b1;
        if (cnt == CntBits'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign remainder = rem[DIV_BITS-1:0];
endmodule
`default_nettype wire
